// File: hw/rtl/alq_pkg.sv
// Shared constants and types of the admission limit queue.
`timescale 1ns / 1ps

package alq_pkg;

  localparam int WAIT_DEPTH_DEF   = 16;
  localparam int ACTIVE_DEPTH_DEF = 8;

  localparam int ID_W       = 8;
  localparam int MAXA_W     = 4;
  localparam int ACNT_W     = 4;
  localparam int WCNT_W     = 5;
  localparam int OUT_DATA_W = 24;

  localparam logic [MAXA_W-1:0] ACT_CAP_RST = 4'd2;

  localparam logic KIND_ENTER = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  // One command per controller phase. Loading the next request may fall in the
  // same cycle as loading the result word; the other commands never overlap.
  typedef struct packed {
    logic load_item;
    logic match;
    logic apply;
    logic promote;
    logic load_out;
  } alq_cmd_t;

endpackage

// File: hw/rtl/alq_ctrl.sv
// Sequencer of the admission limit queue: steps one request through its phases.
`timescale 1ns / 1ps

module alq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output alq_pkg::alq_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_MATCH   = 5'b00010,
    ST_APPLY   = 5'b00100,
    ST_PROMOTE = 5'b01000,
    ST_RESULT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) || ((state_r == ST_RESULT) && out_free);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.load_item = accept;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_PROMOTE;
      end
      ST_PROMOTE: begin
        cmd.promote = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        // The next request may enter in the same cycle as the result word leaves.
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = in_tvalid ? ST_MATCH : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/alq_datapath.sv
// Datapath of the admission limit queue: id stores, fills, match logic and result word.
`timescale 1ns / 1ps

module alq_datapath #(
  parameter int WAIT_DEPTH   = alq_pkg::WAIT_DEPTH_DEF,
  parameter int ACTIVE_DEPTH = alq_pkg::ACTIVE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  alq_pkg::alq_cmd_t               cmd,
  input  logic                            cfg_wr,
  input  logic [alq_pkg::MAXA_W-1:0]      cfg_value,
  input  logic                            in_kind,
  input  logic [alq_pkg::ID_W-1:0]        in_id,
  output logic [alq_pkg::OUT_DATA_W-1:0]  out_data
);

  localparam int ID_W = alq_pkg::ID_W;
  localparam int WW   = $clog2(WAIT_DEPTH + 1);
  localparam int AW   = $clog2(ACTIVE_DEPTH + 1);
  localparam int WLOG = $clog2(WAIT_DEPTH);
  localparam int ALOG = $clog2(ACTIVE_DEPTH);
  localparam int CW   = (AW > alq_pkg::MAXA_W) ? AW : alq_pkg::MAXA_W;
  localparam int ACW  = (AW > alq_pkg::ACNT_W) ? AW : alq_pkg::ACNT_W;
  localparam int WCW  = (WW > alq_pkg::WCNT_W) ? WW : alq_pkg::WCNT_W;
  localparam int PADW = alq_pkg::OUT_DATA_W - 3 - ID_W - alq_pkg::ACNT_W - alq_pkg::WCNT_W;

  localparam logic [WW-1:0] WAIT_FULL  = WW'(WAIT_DEPTH);
  localparam logic [CW-1:0] ACT_LIMIT  = CW'(ACTIVE_DEPTH);

  logic [ID_W-1:0] wait_ids_r [WAIT_DEPTH];
  logic [ID_W-1:0] wait_ids_nxt [WAIT_DEPTH];
  logic [ID_W-1:0] act_ids_r [ACTIVE_DEPTH];
  logic [ID_W-1:0] act_ids_nxt [ACTIVE_DEPTH];
  logic [WW-1:0]   wait_fill_r, wait_fill_nxt;
  logic [AW-1:0]   act_fill_r, act_fill_nxt;
  logic [alq_pkg::MAXA_W-1:0] act_cap_r, act_cap_nxt;

  logic            kind_r, kind_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [WAIT_DEPTH-1:0]   wait_match_r, wait_match_nxt;
  logic [ACTIVE_DEPTH-1:0] act_match_r, act_match_nxt;
  logic [WAIT_DEPTH-1:0]   wait_from;
  logic [ACTIVE_DEPTH-1:0] act_from;
  logic            try_promote_r, try_promote_nxt;
  logic            grant_r, grant_nxt;
  logic [ID_W-1:0] gid_r, gid_nxt;
  logic            nf_r, nf_nxt;
  logic            rej_r, rej_nxt;
  logic [alq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [CW-1:0]  limit;
  logic           slot_free;
  logic [ACW-1:0] act_cnt_wide;
  logic [WCW-1:0] wait_cnt_wide;

  assign limit     = (CW'(act_cap_r) > ACT_LIMIT) ? ACT_LIMIT : CW'(act_cap_r);
  assign slot_free = CW'(act_fill_r) < limit;
  assign act_cnt_wide  = ACW'(act_fill_r);
  assign wait_cnt_wide = WCW'(wait_fill_r);
  assign out_data      = out_data_r;

  // Entries at and above the first match move down by one: a prefix OR
  // built in log2(depth) levels marks them.
  always_comb begin
    wait_from = wait_match_r;
    for (int k = 0; k < WLOG; k++) begin
      wait_from = wait_from | (wait_from << (1 << k));
    end
    act_from = act_match_r;
    for (int k = 0; k < ALOG; k++) begin
      act_from = act_from | (act_from << (1 << k));
    end
  end

  always_comb begin
    wait_ids_nxt    = wait_ids_r;
    act_ids_nxt     = act_ids_r;
    wait_fill_nxt   = wait_fill_r;
    act_fill_nxt    = act_fill_r;
    act_cap_nxt     = act_cap_r;
    kind_nxt        = kind_r;
    id_nxt          = id_r;
    wait_match_nxt  = wait_match_r;
    act_match_nxt   = act_match_r;
    try_promote_nxt = try_promote_r;
    grant_nxt       = grant_r;
    gid_nxt         = gid_r;
    nf_nxt          = nf_r;
    rej_nxt         = rej_r;
    out_data_nxt    = out_data_r;

    if (cfg_wr) act_cap_nxt = cfg_value;

    if (cmd.load_item) begin
      kind_nxt = in_kind;
      id_nxt   = in_id;
    end

    if (cmd.match) begin
      for (int i = 0; i < WAIT_DEPTH; i++) begin
        wait_match_nxt[i] = (wait_ids_r[i] == id_r) && (WW'(i) < wait_fill_r);
      end
      for (int i = 0; i < ACTIVE_DEPTH; i++) begin
        act_match_nxt[i] = (act_ids_r[i] == id_r) && (AW'(i) < act_fill_r);
      end
    end

    if (cmd.apply) begin
      nf_nxt          = 1'b0;
      rej_nxt         = 1'b0;
      try_promote_nxt = 1'b0;
      if (kind_r == alq_pkg::KIND_ENTER) begin
        try_promote_nxt = 1'b1;
        if (wait_fill_r != WAIT_FULL) begin
          for (int i = 0; i < WAIT_DEPTH; i++) begin
            if (WW'(i) == wait_fill_r) wait_ids_nxt[i] = id_r;
          end
          wait_fill_nxt = wait_fill_r + WW'(1);
        end else begin
          rej_nxt = 1'b1;
        end
      end else if (|act_match_r) begin
        for (int i = 0; i < ACTIVE_DEPTH - 1; i++) begin
          if (act_from[i]) act_ids_nxt[i] = act_ids_r[i+1];
        end
        act_fill_nxt    = act_fill_r - AW'(1);
        try_promote_nxt = 1'b1;
      end else if (|wait_match_r) begin
        // A waiter that leaves frees no slot, so no promotion follows.
        for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
          if (wait_from[i]) wait_ids_nxt[i] = wait_ids_r[i+1];
        end
        wait_fill_nxt = wait_fill_r - WW'(1);
      end else begin
        nf_nxt = 1'b1;
      end
    end

    if (cmd.promote) begin
      grant_nxt = 1'b0;
      gid_nxt   = '0;
      if (try_promote_r && (wait_fill_r != '0) && slot_free) begin
        grant_nxt = 1'b1;
        gid_nxt   = wait_ids_r[0];
        for (int i = 0; i < ACTIVE_DEPTH; i++) begin
          if (AW'(i) == act_fill_r) act_ids_nxt[i] = wait_ids_r[0];
        end
        for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
          wait_ids_nxt[i] = wait_ids_r[i+1];
        end
        act_fill_nxt  = act_fill_r + AW'(1);
        wait_fill_nxt = wait_fill_r - WW'(1);
      end
    end

    if (cmd.load_out) begin
      out_data_nxt = {{PADW{1'b0}},
                      wait_cnt_wide[alq_pkg::WCNT_W-1:0],
                      act_cnt_wide[alq_pkg::ACNT_W-1:0],
                      rej_r, nf_r, gid_r, grant_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_fill_r <= '0;
      act_fill_r  <= '0;
      act_cap_r   <= alq_pkg::ACT_CAP_RST;
    end else begin
      wait_fill_r <= wait_fill_nxt;
      act_fill_r  <= act_fill_nxt;
      act_cap_r   <= act_cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wait_ids_r    <= wait_ids_nxt;
    act_ids_r     <= act_ids_nxt;
    kind_r        <= kind_nxt;
    id_r          <= id_nxt;
    wait_match_r  <= wait_match_nxt;
    act_match_r   <= act_match_nxt;
    try_promote_r <= try_promote_nxt;
    grant_r       <= grant_nxt;
    gid_r         <= gid_nxt;
    nf_r          <= nf_nxt;
    rej_r         <= rej_nxt;
    out_data_r    <= out_data_nxt;
  end

endmodule

// File: hw/rtl/admission_limit_queue_core.sv
// Top level of the admission limit queue: controller, datapath and checks.
`timescale 1ns / 1ps
// Admission limiter with a FIFO of waiting ids and an ordered set of active ids.
// Input stream: in_tuser carries the kind (enter or exit), in_tdata the
// requester id. Each accepted word yields exactly one result word on the out_
// stream with the grant, the granted id, the not-found and rejected flags and
// the active and waiting counts after the request.
// A result word is loaded into the output register in the result phase of its
// request, when that register is free. The sequencer walks each request through
// match, apply, promote and result phases, so a new request is not taken until
// the one before reaches its result phase, where the next request may enter.
// A finished result may wait in the output register while the next request is
// taken; if the receiver stalls longer, the sequencer holds in its result phase
// and in_tready stays low until the output register empties.
// cfg_ready is always high; the active limit is written through cfg_data and
// should only change while no request is in flight. Values above ACTIVE_DEPTH
// act as ACTIVE_DEPTH, zero blocks all grants.
// Reset (rst_n low, synchronous) empties both stores, sets the active limit to
// two and drops any pending result word.

module admission_limit_queue_core #(
  parameter int WAIT_DEPTH   = alq_pkg::WAIT_DEPTH_DEF,
  parameter int ACTIVE_DEPTH = alq_pkg::ACTIVE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [alq_pkg::ID_W-1:0]       in_tdata,   // [7:0] requester_id
  input  logic                           in_tuser,   // [0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] grant, [8:1] granted_id, [9] not_found, [10] rejected_full,
  // [14:11] active_count, [19:15] waiting_count, [23:20] zero
  output logic [alq_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [alq_pkg::MAXA_W-1:0]     cfg_data    // [3:0] active limit
);

  alq_pkg::alq_cmd_t cmd;

  assign cfg_ready = 1'b1;

  alq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  alq_datapath #(
    .WAIT_DEPTH   (WAIT_DEPTH),
    .ACTIVE_DEPTH (ACTIVE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .in_kind   (in_tuser),
    .in_id     (in_tdata),
    .out_data  (out_tdata)
  );

  // A taken request occupies the sequencer: no second word in the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while another is in flight");

  // Each request runs through match, apply and promote in consecutive cycles.
  a_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##1 cmd.match ##1 cmd.apply ##1 cmd.promote)
    else $error("request phases out of order");

  // A result never reports a grant without an active requester.
  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[14:11] != '0))
    else $error("grant reported with no active requester");

  // not_found excludes the other flags: set only on an exit, which never rejects or
  // grants without a removal.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[9] && (out_tdata[10] || out_tdata[0])))
    else $error("inconsistent result flags");

  // Without a grant the granted id reads zero.
  a_gid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[8:1] == '0))
    else $error("granted id set without a grant");

endmodule
